// ----- rtl/core/crpsm_pkg.sv -----
// Package for the class-partitioned replay slot manager.
// Field widths, result codes, register indexes and controller/datapath structs.
// No dependencies.
package crpsm_pkg;

    localparam int MAX_CLASSES_DEF = 64;
    localparam int MAX_SLOTS_DEF   = 1024;

    localparam int KW         = 7;
    localparam int NW         = 11;
    localparam int LABEL_W    = 6;
    localparam int CAND_W     = 16;
    localparam int SDRAW_W    = 10;
    localparam int IDX_W      = 20;
    localparam int OC_W       = 3;
    localparam int CLS_W      = 6;
    localparam int SLOT_W     = 10;
    localparam int ADDR_W     = 16;
    localparam int TOT_W      = 17;
    localparam int SEEN_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [NW-1:0]    N_RST   = NW'(1024);
    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    localparam logic [OC_W-1:0] OC_NEW   = 3'd0;
    localparam logic [OC_W-1:0] OC_REPL  = 3'd1;
    localparam logic [OC_W-1:0] OC_DROP  = 3'd2;
    localparam logic [OC_W-1:0] OC_FOUND = 3'd3;
    localparam logic [OC_W-1:0] OC_EMPTY = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CLASSES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT  = 2'd2;

    typedef struct packed {
        logic clr;
        logic load;
        logic upd;
        logic take_slot;
        logic scan;
        logic div2;
        logic find_start;
        logic find;
        logic set_empty;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic repl;
        logic div_busy;
        logic scan_done;
        logic ne_zero;
        logic hit;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/core/crpsm_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Uses crpsm_pkg widths; instantiated by crpsm_dp.
module crpsm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [crpsm_pkg::IDX_W-1:0]  i_dividend,
    input  logic [crpsm_pkg::NW-1:0]     i_divisor,
    output logic                         o_busy,
    output logic [crpsm_pkg::IDX_W-1:0]  o_quot,
    output logic [crpsm_pkg::NW-1:0]     o_rem
);
    import crpsm_pkg::*;

    localparam int CW = $clog2(IDX_W);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [IDX_W-1:0] r_quot;
    logic [NW-1:0]    r_rem;
    logic [NW-1:0]    r_dv;
    logic [NW:0]      w_trial;
    logic [NW:0]      w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_quot[IDX_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dv};
    assign w_diff  = w_trial - {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(IDX_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dv   <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[NW-1:0] : w_trial[NW-1:0];
            r_quot <= {r_quot[IDX_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/core/crpsm_dp.sv -----
// Datapath: config registers, fill and seen memories, scan counters, divider, result regs.
// Depends on crpsm_pkg and crpsm_div; driven by crpsm_ctrl commands.
module crpsm_dp #(
    parameter int MAX_CLASSES = crpsm_pkg::MAX_CLASSES_DEF,
    parameter int MAX_SLOTS   = crpsm_pkg::MAX_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  crpsm_pkg::t_cmd                   i_cmd,
    output crpsm_pkg::t_sts                   o_sts,
    input  logic                              i_cfg_we,
    input  logic [crpsm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [crpsm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_mode,
    input  logic [crpsm_pkg::LABEL_W-1:0]     i_label,
    input  logic [crpsm_pkg::CAND_W-1:0]      i_candidate_draw,
    input  logic [crpsm_pkg::SDRAW_W-1:0]     i_slot_draw,
    input  logic [crpsm_pkg::IDX_W-1:0]       i_sample_index,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [crpsm_pkg::OC_W-1:0]        o_outcome,
    output logic [crpsm_pkg::CLS_W-1:0]       o_class_out,
    output logic [crpsm_pkg::SLOT_W-1:0]      o_slot_out,
    output logic [crpsm_pkg::ADDR_W-1:0]      o_buffer_address,
    output logic [crpsm_pkg::TOT_W-1:0]       o_total_stored
);
    import crpsm_pkg::*;

    localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int XW = (AW > KW) ? AW : KW;
    localparam int PW = KW + NW;

    // config
    logic [KW-1:0]     r_k;
    logic [NW-1:0]     r_n;
    logic [CAND_W-1:0] r_acc;
    logic [KW-1:0]     w_k;
    logic [NW-1:0]     w_n;

    // item
    logic [LABEL_W-1:0] w_lbl;
    logic [LABEL_W-1:0] r_label;
    logic               r_bad;
    logic [CAND_W-1:0]  r_cand;
    logic [SDRAW_W-1:0] r_sdraw;

    // memories
    logic [NW-1:0]     m_fill [MAX_CLASSES];
    logic [SEEN_W-1:0] m_seen [MAX_CLASSES];
    logic [NW-1:0]     r_fill_rd;
    logic [SEEN_W-1:0] r_seen_rd;
    logic [AW-1:0]     r_clr_addr;
    logic [XW-1:0]     w_lbl_x;
    logic [XW-1:0]     w_cnt_x;
    logic [AW-1:0]     w_wr_addr;
    logic [AW-1:0]     w_rd_addr;
    logic              w_fill_we;
    logic              w_seen_we;

    // insert decision
    logic w_full;
    logic w_drop;
    logic w_repl;

    // scan
    logic [KW-1:0] r_cnt;
    logic [KW-1:0] r_pidx;
    logic          r_pend;
    logic [KW-1:0] r_ne;
    logic [KW-1:0] r_j;
    logic [KW-1:0] r_q;
    logic [NW-1:0] r_ridx;
    logic          w_more;
    logic          w_nz;
    logic          w_hit;
    logic          w_scan_rst;

    // divider
    logic             w_div_start;
    logic [IDX_W-1:0] w_div_dd;
    logic [NW-1:0]    w_div_dv;
    logic             w_div_busy;
    logic [IDX_W-1:0] w_div_quot;
    logic [NW-1:0]    w_div_rem;

    // result
    logic [OC_W-1:0]  r_oc;
    logic [KW-1:0]    r_cls;
    logic [NW-1:0]    r_slot;
    logic [TOT_W-1:0] r_total;
    logic [PW-1:0]    w_addr;

    logic              r_out_valid;
    logic [OC_W-1:0]   r_o_oc;
    logic [CLS_W-1:0]  r_o_cls;
    logic [SLOT_W-1:0] r_o_slot;
    logic [ADDR_W-1:0] r_o_addr;
    logic [TOT_W-1:0]  r_o_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= KW'(1);
            r_n   <= N_RST;
            r_acc <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CLASSES: r_k   <= i_cfg_data[KW-1:0];
                CFG_SLOTS:   r_n   <= i_cfg_data[NW-1:0];
                CFG_ACCEPT:  r_acc <= i_cfg_data[CAND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_k == '0) begin
            w_k = KW'(1);
        end else if (int'(r_k) > MAX_CLASSES) begin
            w_k = KW'(MAX_CLASSES);
        end else begin
            w_k = r_k;
        end
        if (r_n == '0) begin
            w_n = NW'(1);
        end else if (int'(r_n) > MAX_SLOTS) begin
            w_n = NW'(MAX_SLOTS);
        end else begin
            w_n = r_n;
        end
    end

    assign w_lbl = (w_k == KW'(1)) ? '0 : i_label;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_label <= w_lbl;
            r_bad   <= {1'b0, w_lbl} >= w_k;
            r_cand  <= i_candidate_draw;
            r_sdraw <= i_slot_draw;
        end
    end

    // memory ports
    assign w_lbl_x   = XW'(r_label);
    assign w_cnt_x   = XW'(r_cnt);
    assign w_wr_addr = i_cmd.clr ? r_clr_addr : w_lbl_x[AW-1:0];
    assign w_rd_addr = (i_cmd.scan || i_cmd.find) ? w_cnt_x[AW-1:0] : w_lbl_x[AW-1:0];

    assign w_full = r_fill_rd >= w_n;
    assign w_drop = r_bad || (w_full && (r_cand >= r_acc));
    assign w_repl = !w_drop && w_full;

    assign w_fill_we = i_cmd.clr || (i_cmd.upd && !w_drop && !w_full);
    assign w_seen_we = i_cmd.clr || (i_cmd.upd && !w_drop);

    always_ff @(posedge i_clk) begin
        if (w_fill_we) begin
            m_fill[w_wr_addr] <= i_cmd.clr ? '0 : r_fill_rd + NW'(1);
        end
        if (w_seen_we) begin
            m_seen[w_wr_addr] <= i_cmd.clr ? '0 : r_seen_rd + SEEN_W'(1);
        end
        r_fill_rd <= m_fill[w_rd_addr];
        r_seen_rd <= m_seen[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // class scan: one fill count per cycle, read data arrives the cycle after r_cnt addresses it
    assign w_more     = r_cnt != w_k;
    assign w_nz       = r_fill_rd != '0;
    assign w_hit      = i_cmd.find && r_pend && w_nz && (r_j == r_q);
    assign w_scan_rst = (i_cmd.load && i_mode) || i_cmd.find_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_cnt  <= '0;
            r_j    <= '0;
            r_ne   <= '0;
        end else begin
            if (w_scan_rst) begin
                r_cnt  <= '0;
                r_pend <= 1'b0;
                r_j    <= '0;
            end else if (i_cmd.scan || i_cmd.find) begin
                r_pend <= w_more;
                if (w_more) begin
                    r_cnt <= r_cnt + KW'(1);
                end
                if (i_cmd.find && r_pend && w_nz && !w_hit) begin
                    r_j <= r_j + KW'(1);
                end
            end
            if (i_cmd.load) begin
                r_ne <= '0;
            end else if (i_cmd.scan && r_pend && w_nz) begin
                r_ne <= r_ne + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.scan || i_cmd.find) && w_more) begin
            r_pidx <= r_cnt;
        end
        if (i_cmd.div2) begin
            r_ridx <= w_div_rem;
        end
        if (i_cmd.find_start) begin
            r_q <= w_div_rem[KW-1:0];
        end
    end

    always_comb begin
        w_div_start = 1'b0;
        w_div_dd    = '0;
        w_div_dv    = '0;
        if (i_cmd.load && i_mode) begin
            w_div_start = 1'b1;
            w_div_dd    = i_sample_index;
            w_div_dv    = w_n;
        end else if (i_cmd.upd && w_repl) begin
            w_div_start = 1'b1;
            w_div_dd    = IDX_W'(r_sdraw);
            w_div_dv    = w_n;
        end else if (i_cmd.div2) begin
            w_div_start = 1'b1;
            w_div_dd    = w_div_quot;
            w_div_dv    = NW'(r_ne);
        end else if (w_hit) begin
            w_div_start = 1'b1;
            w_div_dd    = IDX_W'(r_ridx);
            w_div_dv    = r_fill_rd;
        end
    end

    crpsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dd),
        .i_divisor  (w_div_dv),
        .o_busy     (w_div_busy),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_cls <= KW'(r_label);
            if (w_drop) begin
                r_oc   <= OC_DROP;
                r_slot <= '0;
            end else if (!w_full) begin
                r_oc   <= OC_NEW;
                r_slot <= r_fill_rd;
            end else begin
                r_oc <= OC_REPL;
            end
        end else if (i_cmd.set_empty) begin
            r_oc   <= OC_EMPTY;
            r_cls  <= '0;
            r_slot <= '0;
        end else if (w_hit) begin
            r_oc  <= OC_FOUND;
            r_cls <= r_pidx;
        end else if (i_cmd.take_slot) begin
            r_slot <= w_div_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.upd && !w_drop && !w_full && (r_total != TOT_MAX)) begin
            r_total <= r_total + TOT_W'(1);
        end
    end

    // result register
    assign w_addr = (PW'(r_cls) * PW'(w_n)) + PW'(r_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_o_oc    <= r_oc;
            r_o_cls   <= r_cls[CLS_W-1:0];
            r_o_slot  <= r_slot[SLOT_W-1:0];
            r_o_addr  <= ((r_oc == OC_DROP) || (r_oc == OC_EMPTY)) ? '0 : w_addr[ADDR_W-1:0];
            r_o_total <= r_total;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_outcome        = r_o_oc;
    assign o_class_out      = r_o_cls;
    assign o_slot_out       = r_o_slot;
    assign o_buffer_address = r_o_addr;
    assign o_total_stored   = r_o_total;

    assign o_sts.clr_last  = r_clr_addr == AW'(MAX_CLASSES - 1);
    assign o_sts.repl      = w_repl;
    assign o_sts.div_busy  = w_div_busy;
    assign o_sts.scan_done = !w_more && !r_pend;
    assign o_sts.ne_zero   = r_ne == '0;
    assign o_sts.hit       = w_hit;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

endmodule

// ----- rtl/core/crpsm_ctrl.sv -----
// Controller state machine: clear pass, insert and lookup sequencing.
// Depends on crpsm_pkg; issues t_cmd to crpsm_dp and reads t_sts back.
module crpsm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_mode,
    input  crpsm_pkg::t_sts i_sts,
    output crpsm_pkg::t_cmd o_cmd,
    output logic            o_in_stall
);
    import crpsm_pkg::*;

    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_IRD   = 9'b000000100,
        S_IUPD  = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_LCNT  = 9'b000100000,
        S_LDIV  = 9'b001000000,
        S_LFIND = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_mode ? S_LCNT : S_IRD;
                end
            end
            S_IRD: begin
                n_state = S_IUPD;
            end
            S_IUPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.repl ? S_DIV : S_FIN;
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.take_slot = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_LCNT: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done && !i_sts.div_busy) begin
                    if (i_sts.ne_zero) begin
                        o_cmd.set_empty = 1'b1;
                        n_state         = S_FIN;
                    end else begin
                        o_cmd.div2 = 1'b1;
                        n_state    = S_LDIV;
                    end
                end
            end
            S_LDIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.find_start = 1'b1;
                    n_state          = S_LFIND;
                end
            end
            S_LFIND: begin
                o_cmd.find = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_DIV;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

// ----- rtl/core/class_partitioned_replay_slot_manager_top.sv -----
// Top level of the class-partitioned replay slot manager.
// Depends on crpsm_pkg, crpsm_ctrl, crpsm_dp (which holds crpsm_div).
//
// Input channel (i_in_valid / o_in_stall): one beat per insert (mode 0) or
// lookup (mode 1). Output channel (o_out_valid / i_out_stall): one result
// beat per input beat, in order. Config: i_cfg_we writes register
// i_cfg_idx (0 classes, 1 slots per class, 2 accept limit); write only idle.
// One item is worked on at a time; stall is high from accept until the
// result is loaded into the output register.
// Insert: accept, fill count read, update, then result; a replace adds a
// run of the 20-step divider that reduces the slot draw.
// Lookup: two passes over the fill counts of the K active classes
// through the single memory read port (one class per cycle) and three
// 20-step divisions on the shared divider.
// Reset: config returns to its defaults, then a clearing pass over all
// MAX_CLASSES entries zeroes the fill and seen memories; no beat is taken
// until it ends. If the receiver stalls, the result waits in the output
// register and the next item finishes its work, then waits behind it.
module class_partitioned_replay_slot_manager_top #(
    parameter int MAX_CLASSES = crpsm_pkg::MAX_CLASSES_DEF,
    parameter int MAX_SLOTS   = crpsm_pkg::MAX_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [crpsm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [crpsm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [crpsm_pkg::LABEL_W-1:0]     i_label,
    input  logic [crpsm_pkg::CAND_W-1:0]      i_candidate_draw,
    input  logic [crpsm_pkg::SDRAW_W-1:0]     i_slot_draw,
    input  logic [crpsm_pkg::IDX_W-1:0]       i_sample_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [crpsm_pkg::OC_W-1:0]        o_outcome,
    output logic [crpsm_pkg::CLS_W-1:0]       o_class_out,
    output logic [crpsm_pkg::SLOT_W-1:0]      o_slot_out,
    output logic [crpsm_pkg::ADDR_W-1:0]      o_buffer_address,
    output logic [crpsm_pkg::TOT_W-1:0]       o_total_stored
);
    import crpsm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    crpsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    crpsm_dp #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_SLOTS   (MAX_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_mode           (i_mode),
        .i_label          (i_label),
        .i_candidate_draw (i_candidate_draw),
        .i_slot_draw      (i_slot_draw),
        .i_sample_index   (i_sample_index),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_outcome        (o_outcome),
        .o_class_out      (o_class_out),
        .o_slot_out       (o_slot_out),
        .o_buffer_address (o_buffer_address),
        .o_total_stored   (o_total_stored)
    );

endmodule

// ----- rtl/core/crpsm_chk.sv -----
// Port-level checker for the replay slot manager, bound to the top level.
// Depends on crpsm_pkg for result codes.
module crpsm_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_we,
    input logic [crpsm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input logic [crpsm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              i_mode,
    input logic [crpsm_pkg::LABEL_W-1:0]     i_label,
    input logic [crpsm_pkg::CAND_W-1:0]      i_candidate_draw,
    input logic [crpsm_pkg::SDRAW_W-1:0]     i_slot_draw,
    input logic [crpsm_pkg::IDX_W-1:0]       i_sample_index,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [crpsm_pkg::OC_W-1:0]        o_outcome,
    input logic [crpsm_pkg::CLS_W-1:0]       o_class_out,
    input logic [crpsm_pkg::SLOT_W-1:0]      o_slot_out,
    input logic [crpsm_pkg::ADDR_W-1:0]      o_buffer_address,
    input logic [crpsm_pkg::TOT_W-1:0]       o_total_stored
);
    import crpsm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_outcome)
            && $stable(o_buffer_address) && $stable(o_total_stored))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second beat taken before first finished");

    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_outcome == OC_DROP) || (o_outcome == OC_EMPTY))
            |-> (o_slot_out == '0) && (o_buffer_address == '0))
        else $error("drop or empty result with nonzero slot");

    a_new_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome == OC_NEW) |-> o_total_stored != '0)
        else $error("new store with zero total");

    a_outcome_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_outcome <= OC_EMPTY)
        else $error("outcome code out of range");

endmodule

bind class_partitioned_replay_slot_manager_top crpsm_chk u_crpsm_chk (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for class_partitioned_replay_slot_manager_top: directed and random insert/lookup
// beats checked against an in-bench model of the per-class fill counts and slot choice.
// Depends on crpsm_pkg and the RTL in rtl/core.
module tb_top;
    import crpsm_pkg::*;

    typedef struct packed {
        logic               mode;
        logic [LABEL_W-1:0] label;
        logic [CAND_W-1:0]  cand;
        logic [SDRAW_W-1:0] sdraw;
        logic [IDX_W-1:0]   idx;
    } slot_req_t;

    typedef struct packed {
        logic [OC_W-1:0]   outcome;
        logic [CLS_W-1:0]  cls;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] addr;
        logic [TOT_W-1:0]  total;
    } slot_result_t;

    class replay_slot_scoreboard;
        logic [KW-1:0]     reg_classes;
        logic [NW-1:0]     reg_slots;
        logic [CAND_W-1:0] reg_accept;
        logic [NW-1:0]     fill [MAX_CLASSES_DEF];
        logic [TOT_W-1:0]  stored;
        slot_result_t      expected_outcomes [$];
        int                mismatches;
        int                checked;
        int                outcome_hits [5];

        function new();
            reg_classes = 1;
            reg_slots   = N_RST;
            reg_accept  = '0;
            stored      = '0;
            mismatches  = 0;
            checked     = 0;
            foreach (fill[i]) fill[i] = '0;
            foreach (outcome_hits[i]) outcome_hits[i] = 0;
        endfunction

        function int unsigned active_classes();
            int unsigned k;
            k = reg_classes;
            if (k < 1) k = 1;
            if (k > MAX_CLASSES_DEF) k = MAX_CLASSES_DEF;
            return k;
        endfunction

        function int unsigned active_slots();
            int unsigned n;
            n = reg_slots;
            if (n < 1) n = 1;
            if (n > MAX_SLOTS_DEF) n = MAX_SLOTS_DEF;
            return n;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CLASSES: reg_classes = data[KW-1:0];
                CFG_SLOTS:   reg_slots   = data[NW-1:0];
                CFG_ACCEPT:  reg_accept  = data;
                default: ;
            endcase
        endfunction

        function void predict_outcome(slot_req_t r);
            int unsigned  k, n, lbl, slot, nonempty, q, j, cls;
            slot_result_t res;
            k   = active_classes();
            n   = active_slots();
            res = '0;
            if (r.mode == 1'b0) begin
                lbl = (k == 1) ? 0 : r.label;
                res.cls = CLS_W'(lbl);
                res.outcome = OC_DROP;
                if (lbl < k) begin
                    if (fill[lbl] < n) begin
                        slot = fill[lbl];
                        fill[lbl] = fill[lbl] + 1'b1;
                        if (stored != TOT_MAX) stored = stored + 1'b1;
                        res.outcome = OC_NEW;
                        res.slot = SLOT_W'(slot);
                        res.addr = ADDR_W'(lbl * n + slot);
                    end else if (r.cand < reg_accept) begin
                        slot = r.sdraw % n;
                        res.outcome = OC_REPL;
                        res.slot = SLOT_W'(slot);
                        res.addr = ADDR_W'(lbl * n + slot);
                    end
                end
            end else begin
                nonempty = 0;
                for (int i = 0; i < k; i++)
                    if (fill[i] != 0) nonempty++;
                res.outcome = OC_EMPTY;
                if (nonempty != 0) begin
                    q   = (r.idx / n) % nonempty;
                    j   = 0;
                    cls = 0;
                    for (int i = 0; i < k; i++) begin
                        if (fill[i] != 0) begin
                            if (j == q) cls = i;
                            j++;
                        end
                    end
                    slot = (r.idx % n) % fill[cls];
                    res.outcome = OC_FOUND;
                    res.cls  = CLS_W'(cls);
                    res.slot = SLOT_W'(slot);
                    res.addr = ADDR_W'(cls * n + slot);
                end
            end
            res.total = stored;
            expected_outcomes.push_back(res);
        endfunction

        function void check_outcome(slot_result_t got);
            slot_result_t want;
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected: oc=%0d cls=%0d slot=%0d",
                             $time, got.outcome, got.cls, got.slot);
                return;
            end
            want = expected_outcomes.pop_front();
            checked++;
            if (want.outcome <= OC_EMPTY) outcome_hits[want.outcome]++;
            if (got.outcome !== want.outcome || got.cls !== want.cls ||
                got.slot !== want.slot || got.addr !== want.addr || got.total !== want.total) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: exp oc=%0d cls=%0d slot=%0d addr=%0d tot=%0d, got oc=%0d cls=%0d slot=%0d addr=%0d tot=%0d",
                             $time, want.outcome, want.cls, want.slot, want.addr, want.total,
                             got.outcome, got.cls, got.slot, got.addr, got.total);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_mode = 1'b0;
    logic [LABEL_W-1:0]    i_label = '0;
    logic [CAND_W-1:0]     i_candidate_draw = '0;
    logic [SDRAW_W-1:0]    i_slot_draw = '0;
    logic [IDX_W-1:0]      i_sample_index = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [OC_W-1:0]       o_outcome;
    logic [CLS_W-1:0]      o_class_out;
    logic [SLOT_W-1:0]     o_slot_out;
    logic [ADDR_W-1:0]     o_buffer_address;
    logic [TOT_W-1:0]      o_total_stored;

    replay_slot_scoreboard board;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    configs = 0;

    class_partitioned_replay_slot_manager_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_label          (i_label),
        .i_candidate_draw (i_candidate_draw),
        .i_slot_draw      (i_slot_draw),
        .i_sample_index   (i_sample_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_outcome        (o_outcome),
        .o_class_out      (o_class_out),
        .o_slot_out       (o_slot_out),
        .o_buffer_address (o_buffer_address),
        .o_total_stored   (o_total_stored)
    );

    always #5 i_clk = ~i_clk;

    // beat monitor and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            board.predict_outcome(slot_req_t'({i_mode, i_label, i_candidate_draw,
                                               i_slot_draw, i_sample_index}));
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_outcome(slot_result_t'({o_outcome, o_class_out, o_slot_out,
                                                o_buffer_address, o_total_stored}));
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic slot_req_t insert_req(input int unsigned label, cand, sdraw);
        slot_req_t r;
        r       = '0;
        r.label = LABEL_W'(label);
        r.cand  = CAND_W'(cand);
        r.sdraw = SDRAW_W'(sdraw);
        return r;
    endfunction

    function automatic slot_req_t lookup_req(input int unsigned idx);
        slot_req_t r;
        r      = '0;
        r.mode = 1'b1;
        r.idx  = IDX_W'(idx);
        return r;
    endfunction

    task automatic send_req(input slot_req_t r);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_mode, i_label, i_candidate_draw, i_slot_draw, i_sample_index} <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] classes, slots, accept);
        logic [CFG_IDX_W-1:0]  regs [3];
        logic [CFG_DATA_W-1:0] vals [3];
        regs = '{CFG_CLASSES, CFG_SLOTS, CFG_ACCEPT};
        vals = '{classes, slots, accept};
        foreach (regs[r]) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[r];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
            board.write_reg(regs[r], vals[r]);
        end
        i_cfg_we <= 1'b0;
        configs++;
    endtask

    task automatic random_segment(input int count);
        int unsigned k;
        slot_req_t   r;
        k = board.active_classes();
        repeat (count) begin
            r.mode  = 1'($urandom_range(0, 99) < 40);
            r.label = ($urandom_range(0, 9) < 8) ? LABEL_W'($urandom_range(0, k - 1))
                                                 : LABEL_W'($urandom);
            r.cand  = CAND_W'($urandom);
            r.sdraw = SDRAW_W'($urandom);
            r.idx   = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 63))
                                                  : IDX_W'($urandom);
            send_req(r);
        end
        drain();
    endtask

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int                    seg;
        int                    idle_plan [4];
        int                    stall_plan [4];
        logic [CFG_DATA_W-1:0] k_val, n_val, a_val;
        idle_plan  = '{0, 79, 0, 28};
        stall_plan = '{0, 0, 79, 28};
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);

        // reset settings: one class, lookup of an empty buffer, label forced to zero
        send_req(lookup_req(20'hFFFFF));
        send_req(insert_req(63, 16'hFFFF, 10'h3FF));
        send_req(lookup_req(20'hFFFFF));
        drain();

        // label out of range, class filling up, accept limit edges, replace
        load_config(4, 2, 16'h8000);
        send_req(insert_req(5, 0, 0));
        send_req(insert_req(1, 0, 0));
        send_req(insert_req(1, 0, 0));
        send_req(insert_req(1, 16'h8000, 10'h3FF));
        send_req(insert_req(1, 16'h7FFF, 10'h3FF));
        send_req(insert_req(1, 0, 0));
        send_req(lookup_req(0));
        send_req(lookup_req(3));
        send_req(insert_req(63, 0, 0));
        send_req(lookup_req(20'hFFFFF));
        drain();

        // clamped registers; fill above the lowered slot count
        load_config(127, 0, 16'hFFFF);
        send_req(insert_req(1, 16'hFFFE, 10'h2AA));
        send_req(insert_req(1, 16'hFFFF, 10'h155));
        send_req(insert_req(63, 16'hFFFF, 0));
        send_req(lookup_req(20'hFFFFF));
        send_req(lookup_req(0));
        drain();

        load_config(0, 2047, 0);
        send_req(insert_req(42, 0, 0));
        send_req(lookup_req(5));
        send_req(insert_req(0, 16'hFFFF, 10'h3FF));
        drain();

        for (seg = 0; seg < 8; seg++) begin
            idle_pct  = idle_plan[seg / 2];
            stall_pct = stall_plan[seg / 2];
            case ($urandom_range(0, 5))
                0:       k_val = 0;
                1:       k_val = 1;
                2:       k_val = 127;
                3:       k_val = 64;
                default: k_val = CFG_DATA_W'($urandom_range(2, 16));
            endcase
            case ($urandom_range(0, 5))
                0:       n_val = 0;
                1:       n_val = 1;
                2:       n_val = 2047;
                3:       n_val = 1024;
                default: n_val = CFG_DATA_W'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 3))
                0:       a_val = 0;
                1:       a_val = 16'hFFFF;
                default: a_val = CFG_DATA_W'($urandom);
            endcase
            load_config(k_val, n_val, a_val);
            random_segment(200);
        end

        repeat (200) @(posedge i_clk);
        $display("tb_top: %0d result beats checked across %0d register settings",
                 board.checked, configs);
        $display("tb_top: new %0d, replaced %0d, dropped %0d, found %0d, empty %0d",
                 board.outcome_hits[OC_NEW], board.outcome_hits[OC_REPL],
                 board.outcome_hits[OC_DROP], board.outcome_hits[OC_FOUND],
                 board.outcome_hits[OC_EMPTY]);
        if (board.mismatches == 0 && board.expected_outcomes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
